// File: rtl/crce_pkg.sv
// Shared types, widths and a helper function for the Catmull-Rom curve evaluator.
`default_nettype none

package crce_pkg;

   localparam int NUM_STAGES = 7;

   // Field widths of the request and response.
   localparam int COORD_W = 24;
   localparam int T_W     = 17;
   localparam int TS_W    = T_W + 1;
   localparam int OUT_W   = 28;

   // Coefficient widths. The coefficients are kept in Q.8 and scaled on use.
   localparam int CALC_W  = 30;
   localparam int C0_W    = 25;
   localparam int C1_W    = 25;
   localparam int C2_W    = 28;
   localparam int C3_W    = 28;
   localparam int C3X3_W  = 30;

   // Horner accumulator and product widths.
   localparam int P1_W    = C3_W + TS_W;
   localparam int PK1_W   = C3X3_W + TS_W;
   localparam int H2_W    = 38;
   localparam int K2_W    = 40;
   localparam int CV_W    = 40;
   localparam int PH2_W   = H2_W + TS_W;
   localparam int PK2_W   = K2_W + TS_W;
   localparam int H3_W    = 40;
   localparam int K3_W    = 42;
   localparam int PH3_W   = H3_W + TS_W;
   localparam int H4_W    = 42;
   localparam int SAT_W   = 42;

   typedef struct packed {
      logic signed [COORD_W-1:0] p0_x;
      logic signed [COORD_W-1:0] p0_y;
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic        [T_W-1:0]     param_t;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pos_x;
      logic signed [OUT_W-1:0] pos_y;
      logic signed [OUT_W-1:0] tan_x;
      logic signed [OUT_W-1:0] tan_y;
      logic signed [OUT_W-1:0] curv_x;
      logic signed [OUT_W-1:0] curv_y;
   } rsp_type;

   // Per-stage load enables and occupancy, handed from control to the datapath.
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } stage_ctl_type;

   // Clamps a wide signed value to the signed output range.
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-OUT_W:0] upper;
      upper = v[SAT_W-1:OUT_W-1];
      if ((&upper) || (~|upper)) begin
         return v[OUT_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/crce_ctrl.sv
// Valid tracking and stall propagation for the evaluator pipeline.
`default_nettype none

module crce_ctrl
   import crce_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          rsp_stall,
   output stage_ctl_type      ctl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;

   // A stage may load when it is empty or when its contents move on.
   always_comb begin
      ready[NUM_STAGES] = ~rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         ready[i] = ~valid_ff[i] | ready[i+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~ready[0];
   assign ctl.load  = ready[NUM_STAGES-1:0];
   assign ctl.valid = valid_ff;

`ifndef SYNTHESIS
   logic in_acc;
   logic out_acc;
   assign in_acc  = req_valid & ~req_stall;
   assign out_acc = valid_ff[NUM_STAGES-1] & ~rsp_stall;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled while the pipeline has a free slot");

   a_free_output_never_stalls: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled although the output is not stalled");

   a_accept_enters_first_stage: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> valid_ff[0])
      else $error("accepted request did not enter the first stage");

   a_item_count_kept: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) ==
                $past($countones(valid_ff)) + $past(in_acc) - $past(out_acc)))
      else $error("pipeline lost or duplicated an item");
`endif

endmodule

`default_nettype wire

// File: rtl/crce_axis.sv
// One coordinate axis of the evaluator: coefficients, three Horner steps and saturation.
`default_nettype none

module crce_axis
   import crce_pkg::*;
(
   input  wire logic                       clock,
   input  wire stage_ctl_type              ctl,
   input  wire logic signed [COORD_W-1:0]  coord_a,
   input  wire logic signed [COORD_W-1:0]  coord_b,
   input  wire logic signed [COORD_W-1:0]  coord_c,
   input  wire logic signed [COORD_W-1:0]  coord_d,
   input  wire logic        [T_W-1:0]      param_t,
   output logic signed [OUT_W-1:0]         pos,
   output logic signed [OUT_W-1:0]         tan,
   output logic signed [OUT_W-1:0]         curv
);

   // Stage 1: basis coefficients in Q.8.
   logic signed [CALC_W-1:0] ax, bx, cx, dx, c3w;
   logic signed [C0_W-1:0]   c0_1_in, c0_1_ff;
   logic signed [C1_W-1:0]   c1_1_in, c1_1_ff;
   logic signed [C2_W-1:0]   c2_1_in, c2_1_ff;
   logic signed [C3_W-1:0]   c3_1_in, c3_1_ff;
   logic signed [C3X3_W-1:0] c3x3_1_in, c3x3_1_ff;
   logic        [T_W-1:0]    t_1_ff;

   always_comb begin
      ax        = CALC_W'(coord_a);
      bx        = CALC_W'(coord_b);
      cx        = CALC_W'(coord_c);
      dx        = CALC_W'(coord_d);
      c3w       = bx + (bx <<< 1) - ax - cx - (cx <<< 1) + dx;
      c0_1_in   = C0_W'(bx <<< 1);
      c1_1_in   = C1_W'(cx - ax);
      c2_1_in   = C2_W'((ax <<< 1) - (bx <<< 2) - bx + (cx <<< 2) - dx);
      c3_1_in   = C3_W'(c3w);
      c3x3_1_in = C3X3_W'(c3w + (c3w <<< 1));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         c0_1_ff   <= c0_1_in;
         c1_1_ff   <= c1_1_in;
         c2_1_ff   <= c2_1_in;
         c3_1_ff   <= c3_1_in;
         c3x3_1_ff <= c3x3_1_in;
         t_1_ff    <= param_t;
      end
   end

   // Stage 2: first multiply by t, for the point and for both derivatives.
   logic signed [TS_W-1:0]  ts_1;
   logic signed [P1_W-1:0]  p1_2_in, p1_2_ff;
   logic signed [PK1_W-1:0] pk_2_in, pk_2_ff;
   logic signed [C0_W-1:0]  c0_2_ff;
   logic signed [C1_W-1:0]  c1_2_ff;
   logic signed [C2_W-1:0]  c2_2_ff;
   logic        [T_W-1:0]   t_2_ff;

   always_comb begin
      ts_1    = $signed({1'b0, t_1_ff});
      p1_2_in = P1_W'(c3_1_ff) * P1_W'(ts_1);
      pk_2_in = PK1_W'(c3x3_1_ff) * PK1_W'(ts_1);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         p1_2_ff <= p1_2_in;
         pk_2_ff <= pk_2_in;
         c0_2_ff <= c0_1_ff;
         c1_2_ff <= c1_1_ff;
         c2_2_ff <= c2_1_ff;
         t_2_ff  <= t_1_ff;
      end
   end

   // Stage 3: round and add the quadratic term; the second derivative is done here.
   // The coefficients carry Q.8, so rounding the Q.24 product by 2^8 gives Q.16.
   logic signed [PK1_W-1:0] rk_3;
   logic signed [H2_W-1:0]  h2_3_in, h2_3_ff;
   logic signed [K2_W-1:0]  k2_3_in, k2_3_ff;
   logic signed [CV_W-1:0]  cv_3;
   logic signed [OUT_W-1:0] curv_3_in, curv_3_ff;
   logic signed [C0_W-1:0]  c0_3_ff;
   logic signed [C1_W-1:0]  c1_3_ff;
   logic        [T_W-1:0]   t_3_ff;

   always_comb begin
      rk_3      = (pk_2_ff + PK1_W'(128)) >>> 8;
      h2_3_in   = (H2_W'(c2_2_ff) <<< 8) + H2_W'((p1_2_ff + P1_W'(128)) >>> 8);
      k2_3_in   = (K2_W'(c2_2_ff) <<< 9) + K2_W'(rk_3);
      cv_3      = (CV_W'(c2_2_ff) <<< 8) + CV_W'(rk_3);
      curv_3_in = sat_out(SAT_W'((cv_3 + CV_W'(128)) >>> 8));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         h2_3_ff   <= h2_3_in;
         k2_3_ff   <= k2_3_in;
         curv_3_ff <= curv_3_in;
         c0_3_ff   <= c0_2_ff;
         c1_3_ff   <= c1_2_ff;
         t_3_ff    <= t_2_ff;
      end
   end

   // Stage 4: second multiply by t.
   logic signed [TS_W-1:0]  ts_3;
   logic signed [PH2_W-1:0] ph_4_in, ph_4_ff;
   logic signed [PK2_W-1:0] pk_4_in, pk_4_ff;
   logic signed [OUT_W-1:0] curv_4_ff;
   logic signed [C0_W-1:0]  c0_4_ff;
   logic signed [C1_W-1:0]  c1_4_ff;
   logic        [T_W-1:0]   t_4_ff;

   always_comb begin
      ts_3    = $signed({1'b0, t_3_ff});
      ph_4_in = PH2_W'(h2_3_ff) * PH2_W'(ts_3);
      pk_4_in = PK2_W'(k2_3_ff) * PK2_W'(ts_3);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         ph_4_ff   <= ph_4_in;
         pk_4_ff   <= pk_4_in;
         curv_4_ff <= curv_3_ff;
         c0_4_ff   <= c0_3_ff;
         c1_4_ff   <= c1_3_ff;
         t_4_ff    <= t_3_ff;
      end
   end

   // Stage 5: add the linear term; the first derivative is finished here.
   logic signed [H3_W-1:0]  h3_5_in, h3_5_ff;
   logic signed [K3_W-1:0]  k3_5;
   logic signed [OUT_W-1:0] tan_5_in, tan_5_ff;
   logic signed [OUT_W-1:0] curv_5_ff;
   logic signed [C0_W-1:0]  c0_5_ff;
   logic        [T_W-1:0]   t_5_ff;

   always_comb begin
      h3_5_in  = (H3_W'(c1_4_ff) <<< 8) + H3_W'((ph_4_ff + PH2_W'(32768)) >>> 16);
      k3_5     = (K3_W'(c1_4_ff) <<< 8) + K3_W'((pk_4_ff + PK2_W'(32768)) >>> 16);
      tan_5_in = sat_out(SAT_W'((k3_5 + K3_W'(256)) >>> 9));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         h3_5_ff   <= h3_5_in;
         tan_5_ff  <= tan_5_in;
         curv_5_ff <= curv_4_ff;
         c0_5_ff   <= c0_4_ff;
         t_5_ff    <= t_4_ff;
      end
   end

   // Stage 6: third multiply by t, for the point only.
   logic signed [TS_W-1:0]  ts_5;
   logic signed [PH3_W-1:0] ph3_6_in, ph3_6_ff;
   logic signed [OUT_W-1:0] tan_6_ff;
   logic signed [OUT_W-1:0] curv_6_ff;
   logic signed [C0_W-1:0]  c0_6_ff;

   always_comb begin
      ts_5     = $signed({1'b0, t_5_ff});
      ph3_6_in = PH3_W'(h3_5_ff) * PH3_W'(ts_5);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         ph3_6_ff  <= ph3_6_in;
         tan_6_ff  <= tan_5_ff;
         curv_6_ff <= curv_5_ff;
         c0_6_ff   <= c0_5_ff;
      end
   end

   // Stage 7: add the constant term, scale to Q.8 and clamp; this is the output register.
   logic signed [H4_W-1:0]  h4_7;
   logic signed [OUT_W-1:0] pos_7_in, pos_7_ff;
   logic signed [OUT_W-1:0] tan_7_ff;
   logic signed [OUT_W-1:0] curv_7_ff;

   always_comb begin
      h4_7     = (H4_W'(c0_6_ff) <<< 8) + H4_W'((ph3_6_ff + PH3_W'(32768)) >>> 16);
      pos_7_in = sat_out(SAT_W'((h4_7 + H4_W'(256)) >>> 9));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         pos_7_ff  <= pos_7_in;
         tan_7_ff  <= tan_6_ff;
         curv_7_ff <= curv_6_ff;
      end
   end

   assign pos  = pos_7_ff;
   assign tan  = tan_7_ff;
   assign curv = curv_7_ff;

endmodule

`default_nettype wire

// File: rtl/catmull_rom_curve_eval_top.sv
// Top level of the uniform Catmull-Rom curve evaluator.
//
// Each request carries four 2-D control points (signed Q15.8) and a curve
// parameter t (unsigned Q1.16). Each request produces exactly one response
// with the curve point, its first derivative and its second derivative on
// both axes, all signed Q19.8 and clamped to the 28-bit range.
// Both channels use valid and stall: a request is taken at a clock edge with
// req_valid high and req_stall low, and a response is taken at an edge with
// rsp_valid high and rsp_stall low.
// The datapath is a seven-stage pipeline, and one request enters per cycle
// when nothing stalls. An accepted request is loaded into the first stage,
// moves through the stages in order and is shown on the response port from
// the last stage, which is the output register. The three dependent
// multiplies by t of the Horner evaluation each own a stage, which sets the
// depth.
// When the receiver stalls, the response holds and empty stages behind it
// keep filling; req_stall rises only once every stage holds a request.
// Reset is synchronous and active high; it empties the pipeline, and no
// response is shown until new requests arrive.
`default_nettype none

module catmull_rom_curve_eval_top
   import crce_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   stage_ctl_type ctl;

   // Valid bits travel with the data; every stage loads when it is empty or
   // when the stage ahead of it is moving, so bubbles close up under a stall.
   crce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // The two axes are independent and share only the clock, the parameter t and the stage control.
   crce_axis u_axis_x (
      .clock   (clock),
      .ctl     (ctl),
      .coord_a (req_data.p0_x),
      .coord_b (req_data.p1_x),
      .coord_c (req_data.p2_x),
      .coord_d (req_data.p3_x),
      .param_t (req_data.param_t),
      .pos     (rsp_data.pos_x),
      .tan     (rsp_data.tan_x),
      .curv    (rsp_data.curv_x)
   );

   crce_axis u_axis_y (
      .clock   (clock),
      .ctl     (ctl),
      .coord_a (req_data.p0_y),
      .coord_b (req_data.p1_y),
      .coord_c (req_data.p2_y),
      .coord_d (req_data.p3_y),
      .param_t (req_data.param_t),
      .pos     (rsp_data.pos_y),
      .tan     (rsp_data.tan_y),
      .curv    (rsp_data.curv_y)
   );

   // The last stage is the output register, so its valid bit is the response valid.
   assign rsp_valid = ctl.valid[NUM_STAGES-1];

endmodule

`default_nettype wire
